// ===== rtl/core/alle_pkg.sv =====
// Package for the linked list engine: field widths, command codes, and the
// control and status structs between controller and datapath. No dependencies.
`default_nettype none

package alle_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ALLE_MODE_W  = 3;
  localparam int unsigned ALLE_LINK_W  = 7;
  localparam int unsigned ALLE_VAL_W   = 56;
  localparam int unsigned ALLE_IDX_W   = 6;
  localparam int unsigned ALLE_FAULT_W = 2;

  // Parameter defaults
  localparam int unsigned ALLE_DEPTH       = 64;
  localparam int unsigned ALLE_VALUE_CHARS = 7;

  typedef enum logic [ALLE_MODE_W-1:0] {
    MODE_LOAD   = 3'd0,
    MODE_HEAD   = 3'd1,
    MODE_INSERT = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_DUMP   = 3'd4
  } mode_e;

  typedef enum logic [ALLE_FAULT_W-1:0] {
    FAULT_OK   = 2'd0,
    FAULT_FULL = 2'd1,
    FAULT_NONE = 2'd2
  } fault_e;

  // Read address source
  typedef enum logic [1:0] {
    RA_POS  = 2'd0,
    RA_HEAD = 2'd1,
    RA_LINK = 2'd2
  } rd_sel_e;

  // Link write address source
  typedef enum logic {
    LWA_ALLOC = 1'b0,
    LWA_POS   = 1'b1
  } lw_addr_e;

  // Link write data source
  typedef enum logic [1:0] {
    LWD_LINK_IN = 2'd0,
    LWD_HEAD    = 2'd1,
    LWD_RD_LINK = 2'd2,
    LWD_ALLOC   = 2'd3
  } lw_data_e;

  // Head register update source
  typedef enum logic [1:0] {
    HD_POS     = 2'd0,
    HD_ALLOC   = 2'd1,
    HD_RD_LINK = 2'd2
  } head_sel_e;

  // Kind of result written into the output register
  typedef enum logic [2:0] {
    EM_ALLOC = 3'd0,
    EM_NODE  = 3'd1,
    EM_FULL  = 3'd2,
    EM_NONE  = 3'd3,
    EM_EMPTY = 3'd4
  } emit_e;

  typedef struct packed {
    logic      take;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      val_we;
    logic      link_we;
    lw_addr_e  lw_addr;
    lw_data_e  lw_data;
    logic      head_we;
    head_sel_e head_sel;
    logic      alloc_inc;
    logic      k_clr;
    logic      k_inc;
    logic      emit;
    emit_e     emit_kind;
    logic      emit_last;
  } cmd_t;

  typedef struct packed {
    logic                   in_fire;
    logic [ALLE_MODE_W-1:0] mode;
    logic                   pos_neg;
    logic                   pos_ok;
    logic                   head_ok;
    logic                   full;
    logic                   link_ok;
    logic                   dump_last;
    logic                   out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/alle_if.sv =====
// Valid/ready channel interfaces for command items and result items.
// Depends on alle_pkg for the field widths.
`default_nettype none

interface alle_in_if import alle_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic [ALLE_MODE_W-1:0]        mode;
  logic signed [ALLE_LINK_W-1:0] position;
  logic [ALLE_VAL_W-1:0]         item_value;
  logic signed [ALLE_LINK_W-1:0] link_in;

  modport source (output valid, mode, position, item_value, link_in, input ready);
  modport sink   (input valid, mode, position, item_value, link_in, output ready);
endinterface

interface alle_out_if import alle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ALLE_IDX_W-1:0]   node_index;
  logic [ALLE_VAL_W-1:0]   node_value;
  logic                    last;
  logic                    list_empty;
  logic [ALLE_FAULT_W-1:0] fault;

  modport source (output valid, node_index, node_value, last, list_empty, fault,
                  input ready);
  modport sink   (input valid, node_index, node_value, last, list_empty, fault,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/alle_datapath.sv =====
// Datapath of the linked list engine: node stores, head and allocation
// registers, input latch, dump counter and result register. Uses alle_pkg.
`default_nettype none

module alle_datapath import alle_pkg::*; #(
  parameter int unsigned DEPTH       = ALLE_DEPTH,
  parameter int unsigned VALUE_CHARS = ALLE_VALUE_CHARS
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  cmd_t         cmd_i,
  output status_t      status_o,
  alle_in_if.sink      in_i,
  alle_out_if.source   out_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned AW = $clog2(DEPTH + 1);
  localparam int unsigned VW = (VALUE_CHARS * 8 > ALLE_VAL_W) ? ALLE_VAL_W : VALUE_CHARS * 8;

  typedef logic signed [ALLE_LINK_W-1:0] link_t;

  // Node stores
  logic [VW-1:0] value_mem [DEPTH];
  link_t         link_mem  [DEPTH];

  // Latched command item
  logic [ALLE_MODE_W-1:0] mode_q;
  link_t                  pos_q;
  logic [VW-1:0]          val_q;
  link_t                  lnk_q;

  link_t         head_q, head_d;
  logic [AW-1:0] alloc_q;
  logic [IW-1:0] node_q;
  logic [IW-1:0] k_q;
  logic [VW-1:0] rd_val_q;
  link_t         rd_link_q;

  logic          out_valid_q;
  logic [ALLE_IDX_W-1:0]   out_idx_q;
  logic [ALLE_VAL_W-1:0]   out_val_q;
  logic                    out_last_q;
  logic                    out_empty_q;
  logic [ALLE_FAULT_W-1:0] out_fault_q;

  logic [ALLE_IDX_W-1:0]   out_idx_d;
  logic [ALLE_VAL_W-1:0]   out_val_d;
  logic                    out_last_d;
  logic                    out_empty_d;
  logic [ALLE_FAULT_W-1:0] out_fault_d;

  logic [IW-1:0] rd_addr;
  logic [IW-1:0] lw_addr;
  link_t         lw_data;
  logic [IW-1:0] alloc_idx;

  function automatic logic node_ok(link_t x);
    return !x[ALLE_LINK_W-1] && ({1'b0, x[ALLE_LINK_W-2:0]} < ALLE_LINK_W'(DEPTH));
  endfunction

  assign alloc_idx = alloc_q[IW-1:0];

  // Latch the command item on acceptance
  assign in_i.ready = cmd_i.take;

  always_ff @(posedge clk_i) begin
    if (in_i.valid && cmd_i.take) begin
      mode_q <= in_i.mode;
      pos_q  <= in_i.position;
      val_q  <= in_i.item_value[VW-1:0];
      lnk_q  <= in_i.link_in;
    end
  end

  // Select store addresses and link write data
  always_comb begin
    case (cmd_i.rd_sel)
      RA_POS:  rd_addr = pos_q[IW-1:0];
      RA_HEAD: rd_addr = head_q[IW-1:0];
      RA_LINK: rd_addr = rd_link_q[IW-1:0];
      default: rd_addr = pos_q[IW-1:0];
    endcase
    lw_addr = (cmd_i.lw_addr == LWA_POS) ? pos_q[IW-1:0] : alloc_idx;
    case (cmd_i.lw_data)
      LWD_LINK_IN: lw_data = lnk_q;
      LWD_HEAD:    lw_data = head_q;
      LWD_RD_LINK: lw_data = rd_link_q;
      LWD_ALLOC:   lw_data = ALLE_LINK_W'(alloc_q);
      default:     lw_data = lnk_q;
    endcase
  end

  // Node stores: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.val_we) begin
      value_mem[alloc_idx] <= val_q;
    end
    if (cmd_i.rd_en) begin
      rd_val_q <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_we) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (cmd_i.rd_en) begin
      rd_link_q <= link_mem[rd_addr];
      node_q    <= rd_addr;
    end
  end

  // Next head value
  always_comb begin
    case (cmd_i.head_sel)
      HD_POS:     head_d = node_ok(pos_q) ? pos_q : '1;
      HD_ALLOC:   head_d = ALLE_LINK_W'(alloc_q);
      HD_RD_LINK: head_d = rd_link_q;
      default:    head_d = head_q;
    endcase
  end

  // Head, allocation count and dump counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '1;
      alloc_q <= '0;
      k_q     <= '0;
    end else begin
      if (cmd_i.head_we) begin
        head_q <= head_d;
      end
      if (cmd_i.alloc_inc) begin
        alloc_q <= alloc_q + AW'(1);
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + IW'(1);
      end
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Shape the result fields for the kind of item emitted
  always_comb begin
    out_idx_d   = '0;
    out_val_d   = '0;
    out_last_d  = 1'b1;
    out_empty_d = 1'b0;
    out_fault_d = FAULT_OK;
    case (cmd_i.emit_kind)
      EM_ALLOC: out_idx_d = ALLE_IDX_W'(alloc_q);
      EM_NODE: begin
        out_idx_d  = ALLE_IDX_W'(node_q);
        out_val_d  = ALLE_VAL_W'(rd_val_q);
        out_last_d = cmd_i.emit_last;
      end
      EM_FULL:  out_fault_d = FAULT_FULL;
      EM_NONE:  out_fault_d = FAULT_NONE;
      EM_EMPTY: out_empty_d = 1'b1;
      default:  out_fault_d = FAULT_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q   <= out_idx_d;
      out_val_q   <= out_val_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_fault_q <= out_fault_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.node_index = out_idx_q;
  assign out_o.node_value = out_val_q;
  assign out_o.last       = out_last_q;
  assign out_o.list_empty = out_empty_q;
  assign out_o.fault      = out_fault_q;

  // Status towards the controller
  always_comb begin
    status_o.in_fire   = in_i.valid && cmd_i.take;
    status_o.mode      = mode_q;
    status_o.pos_neg   = pos_q[ALLE_LINK_W-1];
    status_o.pos_ok    = node_ok(pos_q);
    status_o.head_ok   = node_ok(head_q);
    status_o.full      = alloc_q >= AW'(DEPTH);
    status_o.link_ok   = node_ok(rd_link_q);
    status_o.dump_last = !node_ok(rd_link_q) || (k_q == IW'(DEPTH - 1));
    status_o.out_free  = !out_valid_q || out_o.ready;
  end

endmodule

`default_nettype wire

// ===== rtl/core/alle_ctrl.sv =====
// Controller of the linked list engine: one-hot state machine that sequences
// store reads, writes and result emission. Uses alle_pkg.
`default_nettype none

module alle_ctrl import alle_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  status_t   status_i,
  output cmd_t      cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_DECODE     = 8'b0000_0010,
    S_INS_LINK   = 8'b0000_0100,
    S_INS_FIX    = 8'b0000_1000,
    S_REM_HEAD   = 8'b0001_0000,
    S_REM_FIND   = 8'b0010_0000,
    S_REM_UNLINK = 8'b0100_0000,
    S_DUMP       = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Issue commands and pick the next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.take = 1'b1;
        if (status_i.in_fire) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        case (mode_e'(status_i.mode))
          MODE_LOAD: begin
            if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (status_i.full) begin
                cmd_o.emit_kind = EM_FULL;
              end else begin
                cmd_o.emit_kind = EM_ALLOC;
                cmd_o.val_we    = 1'b1;
                cmd_o.link_we   = 1'b1;
                cmd_o.lw_addr   = LWA_ALLOC;
                cmd_o.lw_data   = LWD_LINK_IN;
                cmd_o.alloc_inc = 1'b1;
              end
            end
          end

          MODE_HEAD: begin
            cmd_o.head_we  = 1'b1;
            cmd_o.head_sel = HD_POS;
            state_d        = S_IDLE;
          end

          MODE_INSERT: begin
            if (!status_i.pos_neg && status_i.pos_ok && !status_i.full) begin
              // fetch the successor of the target node
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_POS;
              state_d      = S_INS_LINK;
            end else if (status_i.out_free) begin
              cmd_o.emit = 1'b1;
              state_d    = S_IDLE;
              if (!status_i.pos_neg) begin
                cmd_o.emit_kind = status_i.pos_ok ? EM_FULL : EM_NONE;
              end else if (status_i.full) begin
                cmd_o.emit_kind = EM_FULL;
              end else begin
                cmd_o.emit_kind = EM_ALLOC;
                cmd_o.val_we    = 1'b1;
                cmd_o.link_we   = 1'b1;
                cmd_o.lw_addr   = LWA_ALLOC;
                cmd_o.lw_data   = LWD_HEAD;
                cmd_o.head_we   = 1'b1;
                cmd_o.head_sel  = HD_ALLOC;
                cmd_o.alloc_inc = 1'b1;
              end
            end
          end

          MODE_REMOVE: begin
            if (status_i.pos_neg && status_i.head_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_HEAD;
              state_d      = S_REM_HEAD;
            end else if (!status_i.pos_neg && status_i.pos_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_POS;
              state_d      = S_REM_FIND;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = EM_NONE;
              state_d         = S_IDLE;
            end
          end

          MODE_DUMP: begin
            if (status_i.head_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RA_HEAD;
              cmd_o.k_clr  = 1'b1;
              state_d      = S_DUMP;
            end else if (status_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_kind = EM_EMPTY;
              state_d         = S_IDLE;
            end
          end

          default: state_d = S_IDLE;
        endcase
      end

      // New node takes the old successor and the value
      S_INS_LINK: begin
        cmd_o.val_we  = 1'b1;
        cmd_o.link_we = 1'b1;
        cmd_o.lw_addr = LWA_ALLOC;
        cmd_o.lw_data = LWD_RD_LINK;
        state_d       = S_INS_FIX;
      end

      // Point the target node at the new node and report it
      S_INS_FIX: begin
        if (status_i.out_free) begin
          cmd_o.link_we   = 1'b1;
          cmd_o.lw_addr   = LWA_POS;
          cmd_o.lw_data   = LWD_ALLOC;
          cmd_o.alloc_inc = 1'b1;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_ALLOC;
          state_d         = S_IDLE;
        end
      end

      S_REM_HEAD: begin
        if (status_i.out_free) begin
          cmd_o.head_we   = 1'b1;
          cmd_o.head_sel  = HD_RD_LINK;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_NODE;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end

      // Successor known: fetch it, or report that there is none
      S_REM_FIND: begin
        if (status_i.link_ok) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RA_LINK;
          state_d      = S_REM_UNLINK;
        end else if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_NONE;
          state_d         = S_IDLE;
        end
      end

      S_REM_UNLINK: begin
        if (status_i.out_free) begin
          cmd_o.link_we   = 1'b1;
          cmd_o.lw_addr   = LWA_POS;
          cmd_o.lw_data   = LWD_RD_LINK;
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_NODE;
          cmd_o.emit_last = 1'b1;
          state_d         = S_IDLE;
        end
      end

      // Emit the fetched node and, unless it is the last, fetch the next one in the same cycle
      S_DUMP: begin
        if (status_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_NODE;
          cmd_o.emit_last = status_i.dump_last;
          if (status_i.dump_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_sel = RA_LINK;
            cmd_o.k_inc  = 1'b1;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/array_linked_list_engine.sv =====
// Top level of the array-backed singly linked list engine.
// Depends on alle_pkg, alle_if, alle_ctrl and alle_datapath.
//
// Usage: command items enter on in_i (mode, position, item_value, link_in)
// and result items leave on out_o, both valid/ready; an item moves on an edge
// where valid and ready are both high. One command is worked on at a time:
// in_i.ready is high only while the controller waits for a command.
// Load, set head, insert at the head, errors found at decode and an empty
// dump finish in S_DECODE; remove at the head passes S_REM_HEAD and a
// remove that finds no successor S_REM_FIND; insert after a node passes
// S_INS_LINK and S_INS_FIX, remove after a node S_REM_FIND and S_REM_UNLINK,
// since each store access goes through one registered read port and one
// write port; a dump stays in S_DUMP while it walks the list node by node.
// A result appears on out_o in the cycle after the controller emits it, held
// in an output register, so the next command may be accepted while the last
// result still waits. When the receiver stalls, the controller holds its
// state and the walk of a dump pauses until the result is taken.
// Reset (rst_ni low, asynchronous) empties the list and clears the
// allocation count; node stores are not cleared and need no clearing pass.

`default_nettype none

module array_linked_list_engine import alle_pkg::*; #(
  parameter int unsigned DEPTH       = ALLE_DEPTH,
  parameter int unsigned VALUE_CHARS = ALLE_VALUE_CHARS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  alle_in_if.sink    in_i,
  alle_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;

  alle_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  alle_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_CHARS (VALUE_CHARS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .in_i     (in_i),
    .out_o    (out_o)
  );

endmodule

`default_nettype wire

// ===== bench/array_linked_list_engine_tb.sv =====
// Self-checking bench for array_linked_list_engine: directed and random commands,
// predicted list results checked in order. Depends on alle_pkg, alle_if and the RTL.
`default_nettype none

module array_linked_list_engine_tb;
  import alle_pkg::*;

  localparam int NODES        = ALLE_DEPTH;
  localparam int AT_HEAD      = -1;
  localparam int HEAD_LOWEST  = -(1 << (ALLE_LINK_W - 1));
  localparam int MODE_TOP     = (1 << ALLE_MODE_W) - 1;
  localparam int HOLD_CYCLES  = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 16;
  localparam int MAX_REPORTS  = 60;
  localparam logic [ALLE_VAL_W-1:0] VALUE_MASK =
    (ALLE_VALUE_CHARS * 8 >= ALLE_VAL_W) ? {ALLE_VAL_W{1'b1}} :
    {ALLE_VAL_W{1'b1}} >> (ALLE_VAL_W - ALLE_VALUE_CHARS * 8);

  typedef struct packed {
    logic [ALLE_MODE_W-1:0]        mode;
    logic signed [ALLE_LINK_W-1:0] position;
    logic [ALLE_VAL_W-1:0]         item_value;
    logic signed [ALLE_LINK_W-1:0] link_in;
  } command_t;

  typedef struct packed {
    logic [ALLE_IDX_W-1:0]   node_index;
    logic [ALLE_VAL_W-1:0]   node_value;
    logic                    last;
    logic                    list_empty;
    logic [ALLE_FAULT_W-1:0] fault;
  } answer_t;

  // Shadow of the list store; works out the answers of each accepted command
  class list_scoreboard;
    logic [ALLE_VAL_W-1:0] node_val [NODES];
    int                    node_link[NODES];
    int                    head;
    int                    alloc;
    int                    mismatches;
    int                    answers_seen;
    answer_t               answers_due[$];

    function new();
      head       = AT_HEAD;
      alloc      = 0;
      mismatches = 0;
      answers_seen = 0;
    endfunction

    function bit is_node(int i);
      return i >= 0 && i < NODES;
    endfunction

    function void push_answer(int idx, logic [ALLE_VAL_W-1:0] v, bit fin, bit empty,
                              fault_e f);
      answer_t a;
      a.node_index = ALLE_IDX_W'(idx);
      a.node_value = v;
      a.last       = fin;
      a.list_empty = empty;
      a.fault      = f;
      answers_due.push_back(a);
    endfunction

    // Apply one accepted command to the shadow list and queue its answers
    function void note_command(command_t c);
      int                    pos;
      int                    lnk;
      int                    cur;
      int                    nxt;
      int                    k;
      logic [ALLE_VAL_W-1:0] v;
      pos = $signed(c.position);
      lnk = $signed(c.link_in);
      v   = c.item_value & VALUE_MASK;
      case (c.mode)
        MODE_LOAD: begin
          if (alloc >= NODES) begin
            push_answer(0, '0, 1'b1, 1'b0, FAULT_FULL);
          end else begin
            node_val[alloc]  = v;
            node_link[alloc] = lnk;
            push_answer(alloc, '0, 1'b1, 1'b0, FAULT_OK);
            alloc++;
          end
        end
        MODE_HEAD: begin
          head = is_node(pos) ? pos : AT_HEAD;
        end
        MODE_INSERT: begin
          if (pos >= 0 && !is_node(pos)) begin
            push_answer(0, '0, 1'b1, 1'b0, FAULT_NONE);
          end else if (alloc >= NODES) begin
            push_answer(0, '0, 1'b1, 1'b0, FAULT_FULL);
          end else begin
            node_val[alloc] = v;
            if (pos < 0) begin
              node_link[alloc] = head;
              head = alloc;
            end else begin
              node_link[alloc] = node_link[pos];
              node_link[pos]   = alloc;
            end
            push_answer(alloc, '0, 1'b1, 1'b0, FAULT_OK);
            alloc++;
          end
        end
        MODE_REMOVE: begin
          if (pos < 0) begin
            cur = head;
            if (!is_node(cur)) begin
              push_answer(0, '0, 1'b1, 1'b0, FAULT_NONE);
            end else begin
              head = node_link[cur];
              push_answer(cur, node_val[cur], 1'b1, 1'b0, FAULT_OK);
            end
          end else if (!is_node(pos) || !is_node(node_link[pos])) begin
            push_answer(0, '0, 1'b1, 1'b0, FAULT_NONE);
          end else begin
            cur = node_link[pos];
            node_link[pos] = node_link[cur];
            push_answer(cur, node_val[cur], 1'b1, 1'b0, FAULT_OK);
          end
        end
        MODE_DUMP: begin
          cur = head;
          k   = 0;
          if (!is_node(cur)) begin
            push_answer(0, '0, 1'b1, 1'b1, FAULT_OK);
          end
          // Walk from the head; a long or cyclic list stops after NODES entries
          while (is_node(cur) && k < NODES) begin
            nxt = node_link[cur];
            push_answer(cur, node_val[cur], !is_node(nxt) || k == NODES - 1, 1'b0,
                        FAULT_OK);
            k++;
            cur = nxt;
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("[%0t] mismatch: %s", $realtime, msg);
      end
    endtask

    // Compare one result item with the oldest answer due
    task check_result(answer_t got);
      answer_t want;
      answers_seen++;
      if (answers_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing due", answers_seen));
      end else begin
        want = answers_due.pop_front();
        if (got.node_index !== want.node_index)
          report_mismatch($sformatf("result %0d node_index %0d, want %0d",
                                    answers_seen, got.node_index, want.node_index));
        if (got.node_value !== want.node_value)
          report_mismatch($sformatf("result %0d node_value %h, want %h",
                                    answers_seen, got.node_value, want.node_value));
        if (got.last !== want.last)
          report_mismatch($sformatf("result %0d last %b, want %b",
                                    answers_seen, got.last, want.last));
        if (got.list_empty !== want.list_empty)
          report_mismatch($sformatf("result %0d list_empty %b, want %b",
                                    answers_seen, got.list_empty, want.list_empty));
        if (got.fault !== want.fault)
          report_mismatch($sformatf("result %0d fault %0d, want %0d",
                                    answers_seen, got.fault, want.fault));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_stall_pct;
  bit   hold_req;
  int   hold_left;
  int   quiet;

  list_scoreboard sb = new();

  alle_in_if  in_if();
  alle_out_if out_if();

  array_linked_list_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: long hold-off on request, otherwise random stalls for the phase
  initial out_if.ready = 1'b0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Check every result item taken
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_result('{out_if.node_index, out_if.node_value, out_if.last,
                        out_if.list_empty, out_if.fault});
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, quiet);
        $display("array_linked_list_engine_tb NOT OK");
        $finish;
      end
    end
  end

  function automatic logic [ALLE_VAL_W-1:0] rand_value();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ALLE_VAL_W-1:0];
  endfunction

  function automatic logic signed [ALLE_LINK_W-1:0] any_negative();
    return ALLE_LINK_W'(-int'($urandom_range(1, -HEAD_LOWEST)));
  endfunction

  function automatic logic signed [ALLE_LINK_W-1:0] pick_node(int upper);
    return ALLE_LINK_W'($urandom_range(0, upper));
  endfunction

  // Anchor for insert, remove and set head: the head, or a node already written
  function automatic logic signed [ALLE_LINK_W-1:0] pick_anchor();
    if (sb.alloc == 0 || $urandom_range(0, 2) == 0) return any_negative();
    return pick_node(sb.alloc - 1);
  endfunction

  // Random command whose links and anchors only ever reach written nodes
  function automatic command_t random_command();
    command_t c;
    int       r;
    c.item_value = rand_value();
    c.position   = ALLE_LINK_W'($urandom);
    c.link_in    = ALLE_LINK_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 24) begin
      c.mode = MODE_LOAD;
      if (sb.alloc < NODES) begin
        c.link_in = $urandom_range(0, 1) ? any_negative() : pick_node(sb.alloc);
      end
    end else if (r < 50) begin
      c.mode     = MODE_INSERT;
      c.position = pick_anchor();
    end else if (r < 70) begin
      c.mode     = MODE_REMOVE;
      c.position = pick_anchor();
    end else if (r < 80) begin
      c.mode     = MODE_HEAD;
      c.position = pick_anchor();
    end else if (r < 95) begin
      c.mode = MODE_DUMP;
    end else begin
      c.mode = ALLE_MODE_W'($urandom_range(int'(MODE_DUMP) + 1, MODE_TOP));
    end
    return c;
  endfunction

  // Offer one command after a random gap; returns at the falling edge after acceptance
  task automatic send_command(input command_t c);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= c.mode;
    in_if.position   <= c.position;
    in_if.item_value <= c.item_value;
    in_if.link_in    <= c.link_in;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_command(c);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [ALLE_MODE_W-1:0] mode,
                             input logic signed [ALLE_LINK_W-1:0] pos,
                             input logic [ALLE_VAL_W-1:0] val,
                             input logic signed [ALLE_LINK_W-1:0] link);
    send_command('{mode, pos, val, link});
  endtask

  // Count only commands the block acts on
  task automatic run_random(input int n);
    int       done;
    command_t c;
    done = 0;
    while (done < n) begin
      c = random_command();
      if (c.mode <= MODE_DUMP) done++;
      send_command(c);
    end
  endtask

  // Hold the sender until every answer due has come back
  task automatic await_drain();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.answers_due.size() != 0);
  endtask

  initial begin
    int tx_plan[4];
    int rx_plan[4];
    tx_plan = '{0, 84, 0, 18};
    rx_plan = '{0, 0, 84, 18};
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = '0;
    in_if.position   = '0;
    in_if.item_value = '0;
    in_if.link_in    = '0;
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    hold_req         = 1'b0;
    hold_left        = 0;
    quiet            = 0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Empty list: dump and remove at the head
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    send_fields(MODE_REMOVE, AT_HEAD, rand_value(), AT_HEAD);
    // Build 1 -> 0 -> 3 with value extremes, a load and an insert after a node
    send_fields(MODE_INSERT, AT_HEAD, {ALLE_VAL_W{1'b1}}, AT_HEAD);
    send_fields(MODE_INSERT, HEAD_LOWEST, '0, HEAD_LOWEST);
    send_fields(MODE_LOAD, AT_HEAD, 56'h0123_4567_89AB_CD, AT_HEAD);
    send_fields(MODE_INSERT, 0, rand_value(), AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    // Remove after the tail, after a node, then at the head
    send_fields(MODE_REMOVE, 3, '0, AT_HEAD);
    send_fields(MODE_REMOVE, 1, '0, AT_HEAD);
    send_fields(MODE_REMOVE, HEAD_LOWEST, '0, AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    // Clear the head by a negative position
    send_fields(MODE_HEAD, AT_HEAD, '0, AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    // Self-linked node, then a two-node cycle: dumps stop after NODES entries
    send_fields(MODE_LOAD, AT_HEAD, rand_value(), 4);
    send_fields(MODE_HEAD, 4, '0, AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    send_fields(MODE_INSERT, 4, rand_value(), AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    send_fields(MODE_REMOVE, AT_HEAD, '0, AT_HEAD);
    // Unused modes are dropped without a result
    for (int m = int'(MODE_DUMP) + 1; m <= MODE_TOP; m++) begin
      send_fields(ALLE_MODE_W'(m), ALLE_LINK_W'($urandom), rand_value(),
                  ALLE_LINK_W'($urandom));
    end
    // Remove after the end of a one-node list
    send_fields(MODE_HEAD, 2, '0, AT_HEAD);
    send_fields(MODE_REMOVE, 2, '0, AT_HEAD);
    await_drain();

    // Random phases with different gap and stall mixes
    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_plan[p];
      rx_stall_pct = rx_plan[p];
      if (p == 2) begin
        // Receiver holds off while commands keep coming
        hold_req = 1'b1;
        send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
      end
      run_random(10);
      await_drain();
    end

    // Fill the store; the last node links to itself at the top index
    while (sb.alloc < NODES) begin
      send_fields(MODE_LOAD, ALLE_LINK_W'($urandom), rand_value(),
                  (sb.alloc == NODES - 1) ? ALLE_LINK_W'(NODES - 1) : any_negative());
    end
    send_fields(MODE_LOAD, AT_HEAD, rand_value(), AT_HEAD);
    send_fields(MODE_INSERT, 0, rand_value(), AT_HEAD);
    send_fields(MODE_INSERT, AT_HEAD, rand_value(), AT_HEAD);
    send_fields(MODE_HEAD, NODES - 1, '0, AT_HEAD);
    send_fields(MODE_DUMP, AT_HEAD, '0, AT_HEAD);
    send_fields(MODE_REMOVE, AT_HEAD, '0, AT_HEAD);
    run_random(4);
    await_drain();

    // Let any stray result surface before closing
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (sb.answers_due.size() != 0) begin
      sb.report_mismatch($sformatf("%0d answers never arrived", sb.answers_due.size()));
    end
    if (sb.mismatches == 0) begin
      $display("array_linked_list_engine_tb OK");
    end else begin
      $display("array_linked_list_engine_tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
